// ===== rtl/sevq_pkg.sv =====
`default_nettype none

package sevq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int PID_W  = 16;
    localparam int TIME_W = 32;
    localparam int CPU_W  = 32;
    localparam int FILL_W = 5;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_POP    = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_POPPED   = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [PID_W-1:0]  proc_id;
        logic [TIME_W-1:0] arrive_at;
        logic [CPU_W-1:0]  cpu_need;
    } entry_t;

    // shift commands broadcast to every cell
    typedef struct packed {
        logic do_insert;
        logic do_pop;
    } cell_ctl_t;

    typedef struct packed {
        logic [1:0]        status;
        entry_t            entry;
        logic [FILL_W-1:0] fill;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_event_queue_top.sv =====
// sorted event queue: a row of DEPTH cells holds the entries in arrival-time order, earliest in
// cell 0. Each request (insert or pop) is taken while in_stall is low and its result is
// registered in the output buffer; a sustained rate of one request per cycle, while stall
// stays low, is set by the cell row, where every cell compares its key with the new one at once
// and shifts with its neighbor. The two-entry output buffer lets one request be taken while a
// result waits, and stall rises only when both entries are full. Inserts into a full queue and
// pops from an empty one report their status and leave the queue unchanged.
`default_nettype none

module sorted_event_queue_top
#(
    parameter int DEPTH = sevq_pkg::DEPTH_DEFAULT
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        func,
    input  wire logic [sevq_pkg::PID_W-1:0]  proc_id,
    input  wire logic [sevq_pkg::TIME_W-1:0] arrive_at,
    input  wire logic [sevq_pkg::CPU_W-1:0]  cpu_need,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [1:0]                       status,
    output logic [sevq_pkg::PID_W-1:0]       out_proc_id,
    output logic [sevq_pkg::TIME_W-1:0]      out_arrive_at,
    output logic [sevq_pkg::CPU_W-1:0]       out_cpu_need,
    output logic [sevq_pkg::FILL_W-1:0]      fill
);

    localparam int HW = $clog2(DEPTH + 1);

    logic [HW-1:0]       held_reg;
    logic [HW-1:0]       held_next;
    logic                accept;
    logic                full;
    logic                empty;
    sevq_pkg::cell_ctl_t ctl;
    sevq_pkg::entry_t    new_entry;
    sevq_pkg::entry_t    slot_w [DEPTH];
    logic                ge_w   [DEPTH];
    sevq_pkg::result_t   res;
    sevq_pkg::result_t   out_res;
    logic                busy;

    assign accept = in_valid && !in_stall;
    assign full   = (held_reg == HW'(DEPTH));
    assign empty  = (held_reg == '0);

    assign new_entry.proc_id   = proc_id;
    assign new_entry.arrive_at = arrive_at;
    assign new_entry.cpu_need  = cpu_need;

    assign ctl.do_insert = accept && (func == sevq_pkg::FUNC_INSERT) && !full;
    assign ctl.do_pop    = accept && (func == sevq_pkg::FUNC_POP) && !empty;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            sevq_pkg::entry_t left_e;
            sevq_pkg::entry_t right_e;
            logic             left_g;
            logic             occ;

            assign occ = (HW'(i) < held_reg);

            if (i == 0)
            begin : g_first
                assign left_e = new_entry;
                assign left_g = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = slot_w[i-1];
                assign left_g = ge_w[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_e = slot_w[i];
            end
            else
            begin : g_inner
                assign right_e = slot_w[i+1];
            end

            sevq_cell u_cell
            (
                .clk         (clk),
                .ctl         (ctl),
                .new_entry   (new_entry),
                .occupied    (occ),
                .left_entry  (left_e),
                .left_ge     (left_g),
                .right_entry (right_e),
                .ge          (ge_w[i]),
                .slot        (slot_w[i])
            );
        end
    endgenerate

    always_comb
    begin
        held_next = held_reg;
        if (ctl.do_insert)
        begin
            held_next = held_reg + HW'(1);
        end
        else if (ctl.do_pop)
        begin
            held_next = held_reg - HW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    always_comb
    begin
        res.entry = '0;
        res.fill  = sevq_pkg::FILL_W'(held_next);
        if (func == sevq_pkg::FUNC_INSERT)
        begin
            res.status = full ? sevq_pkg::ST_FULL : sevq_pkg::ST_INSERTED;
        end
        else if (empty)
        begin
            res.status = sevq_pkg::ST_EMPTY;
        end
        else
        begin
            res.status = sevq_pkg::ST_POPPED;
            res.entry  = slot_w[0];
        end
    end

    sevq_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_res  (res),
        .out_stall (out_stall),
        .busy      (busy),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign in_stall      = busy;
    assign status        = out_res.status;
    assign out_proc_id   = out_res.entry.proc_id;
    assign out_arrive_at = out_res.entry.arrive_at;
    assign out_cpu_need  = out_res.entry.cpu_need;
    assign fill          = out_res.fill;

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HW'(DEPTH))
        else $error("entry count above depth");

    a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (func == sevq_pkg::FUNC_INSERT) && full |=> $stable(held_reg))
        else $error("insert on full changed the count");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (func == sevq_pkg::FUNC_POP) && !empty
        |=> held_reg == $past(held_reg) - HW'(1))
        else $error("pop did not drop the count by one");

    a_stall_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("stall raised with no result waiting");

endmodule

`default_nettype wire

// ===== rtl/sevq_cell.sv =====
`default_nettype none

module sevq_cell
(
    input  wire logic               clk,
    input  wire sevq_pkg::cell_ctl_t ctl,
    input  wire sevq_pkg::entry_t   new_entry,
    input  wire logic               occupied,
    input  wire sevq_pkg::entry_t   left_entry,
    input  wire logic               left_ge,
    input  wire sevq_pkg::entry_t   right_entry,
    output logic                    ge,
    output sevq_pkg::entry_t        slot
);

    sevq_pkg::entry_t slot_reg;
    sevq_pkg::entry_t slot_next;

    // true where the new entry belongs at or before this slot
    assign ge = !occupied || (slot_reg.arrive_at >= new_entry.arrive_at);

    always_comb
    begin
        slot_next = slot_reg;
        if (ctl.do_pop)
        begin
            slot_next = right_entry;
        end
        else if (ctl.do_insert && ge)
        begin
            // first slot at or after the key takes the new entry, the rest shift right
            slot_next = left_ge ? left_entry : new_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule

`default_nettype wire

// ===== rtl/sevq_out_buf.sv =====
`default_nettype none

module sevq_out_buf
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire sevq_pkg::result_t push_res,
    input  wire logic              out_stall,
    output logic                   busy,
    output logic                   out_valid,
    output sevq_pkg::result_t      out_res
);

    logic              main_valid_reg;
    logic              main_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    sevq_pkg::result_t main_reg;
    sevq_pkg::result_t skid_reg;
    logic              take;

    assign take = main_valid_reg && !out_stall;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (take)
        begin
            main_valid_next = skid_valid_reg;
            skid_valid_next = 1'b0;
        end
        if (push)
        begin
            if (!main_valid_reg || (take && !skid_valid_reg))
            begin
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && skid_valid_reg)
        begin
            main_reg <= skid_reg;
        end
        if (push)
        begin
            if (!main_valid_reg || (take && !skid_valid_reg))
            begin
                main_reg <= push_res;
            end
            else
            begin
                skid_reg <= push_res;
            end
        end
    end

    assign busy      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

endmodule

`default_nettype wire
